// ===== src/salc_pkg.sv =====
`default_nettype none

package salc_pkg;

    // Default geometry
    localparam int MAX_SETS_DEF  = 8192;
    localparam int MAX_WAYS_DEF  = 4;
    localparam int LINE_BITS_DEF = 27;

    // Fixed field widths
    localparam int ADDR_W     = 27;
    localparam int POS_OUT_W  = 2;
    localparam int COUNT_W    = 48;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int SETB_W     = 4;
    localparam int WAYS_W     = 3;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_INDEX_BITS = 1'b0,
        CFG_WAYS_IN_USE    = 1'b1
    } t_cfg_idx;

    localparam logic [SETB_W-1:0] SET_BITS_RST = 4'd9;
    localparam logic [WAYS_W-1:0] WAYS_RST     = 3'd1;

    // Input transaction
    typedef struct packed {
        logic [ADDR_W-1:0] line_address;
    } t_req;

    // Output transaction
    typedef struct packed {
        logic                 hit;
        logic [POS_OUT_W-1:0] hit_position;
        logic [COUNT_W-1:0]   miss_total;
    } t_rsp;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;   // write an empty row at the clear pointer
        logic take;    // accept transaction, read its set
        logic commit;  // write back set, update counter, load result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;  // clear pointer on the last row
        logic out_free;    // result register can take a new result
    } t_status;

endpackage

`default_nettype wire

// ===== src/salc_stream_if.sv =====
`default_nettype none

interface salc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/salc_ram.sv =====
`default_nettype none

module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic                                i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/salc_ctrl.sv =====
`default_nettype none

module salc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire salc_pkg::t_status i_status,
    output salc_pkg::t_cmd         o_cmd
);

    salc_pkg::t_state r_state;
    salc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= salc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            salc_pkg::ST_CLEAR: begin
                if (i_status.clear_last) n_state = salc_pkg::ST_IDLE;
            end
            salc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = salc_pkg::ST_LOOKUP;
            end
            salc_pkg::ST_LOOKUP: begin
                if (i_status.out_free) n_state = salc_pkg::ST_IDLE;
            end
            default: n_state = salc_pkg::ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            salc_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            salc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            salc_pkg::ST_LOOKUP: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/salc_dp.sv =====
`default_nettype none

module salc_dp #(
    parameter int MAX_SETS  = salc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = salc_pkg::MAX_WAYS_DEF,
    parameter int LINE_BITS = salc_pkg::LINE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire salc_pkg::t_cmd                  i_cmd,
    output salc_pkg::t_status                    o_status,
    input  wire logic [salc_pkg::ADDR_W-1:0]     i_line,
    input  wire logic                            i_cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output salc_pkg::t_rsp                       o_out
);

    localparam int LW      = (LINE_BITS < salc_pkg::ADDR_W) ? LINE_BITS : salc_pkg::ADDR_W;
    localparam int EW      = LW + 1;
    localparam int RW      = MAX_WAYS * EW;
    localparam int IDX_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SET_LOG = $clog2(MAX_SETS + 1) - 1;
    localparam int PW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [salc_pkg::SETB_W-1:0]  r_set_bits;
    logic [salc_pkg::WAYS_W-1:0]  r_ways;
    logic [LW-1:0]                r_line;
    logic [IDX_W-1:0]             r_set;
    logic [IDX_W-1:0]             r_clr;
    logic [salc_pkg::COUNT_W-1:0] r_miss;
    logic [salc_pkg::COUNT_W-1:0] n_miss;
    logic                         r_out_valid;
    salc_pkg::t_rsp               r_out;

    logic [LW-1:0]    line_in;
    logic [31:0]      line_ext;
    logic [4:0]       eff_bits;
    logic [IDX_W-1:0] set_mask;
    logic [IDX_W-1:0] set_in;
    logic [3:0]       eff_ways;
    logic [RW-1:0]    rd_row;
    logic [RW-1:0]    new_row;
    logic [RW-1:0]    wr_row;
    logic [IDX_W-1:0] wr_addr;
    logic [LW-1:0]    old_line [MAX_WAYS];
    logic             old_v    [MAX_WAYS];
    logic             hit;
    logic [PW-1:0]    pos;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= salc_pkg::SET_BITS_RST;
            r_ways     <= salc_pkg::WAYS_RST;
        end else if (i_cfg_we) begin
            unique case (salc_pkg::t_cfg_idx'(i_cfg_index))
                salc_pkg::CFG_SET_INDEX_BITS: r_set_bits <= i_cfg_data;
                salc_pkg::CFG_WAYS_IN_USE:    r_ways     <= i_cfg_data[salc_pkg::WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // Set index of the incoming line, set count clamped to the store
    always_comb begin
        line_in  = i_line[LW-1:0];
        line_ext = 32'(line_in);
        eff_bits = (5'(r_set_bits) > 5'(SET_LOG)) ? 5'(SET_LOG) : 5'(r_set_bits);
        for (int j = 0; j < IDX_W; j++) begin
            set_mask[j] = (5'(j) < eff_bits);
        end
        set_in = line_ext[IDX_W-1:0] & set_mask;
    end

    // Ways in use, clamped to one .. MAX_WAYS
    always_comb begin
        if (r_ways == '0) begin
            eff_ways = 4'd1;
        end else if (4'(r_ways) > 4'(MAX_WAYS)) begin
            eff_ways = 4'(MAX_WAYS);
        end else begin
            eff_ways = 4'(r_ways);
        end
    end

    // Latch the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_line <= line_in;
            r_set  <= set_in;
        end
    end

    // Clear pointer walks every row once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear && !o_status.clear_last) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Unpack the row, search in recency order, lowest match wins
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            old_line[w] = rd_row[w*EW +: LW];
            old_v[w]    = rd_row[w*EW + LW];
        end
        hit = 1'b0;
        pos = PW'(eff_ways - 4'd1);
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if ((4'(w) < eff_ways) && old_v[w] && (old_line[w] == r_line)) begin
                hit = 1'b1;
                pos = PW'(w);
            end
        end
    end

    // Reordered row: line in front, positions ahead of pos shift down
    always_comb begin
        new_row = rd_row;
        new_row[0 +: EW] = {1'b1, r_line};
        for (int k = 1; k < MAX_WAYS; k++) begin
            if (PW'(k) <= pos) begin
                new_row[k*EW +: EW] = rd_row[(k-1)*EW +: EW];
            end
        end
    end

    // Saturating miss count
    always_comb begin
        n_miss = r_miss;
        if (!hit && (r_miss != '1)) begin
            n_miss = r_miss + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= '0;
        end else if (i_cmd.commit) begin
            r_miss <= n_miss;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.hit          <= hit;
            r_out.hit_position <= hit ? salc_pkg::POS_OUT_W'(pos) : '0;
            r_out.miss_total   <= n_miss;
        end
    end

    // Store write: empty rows during the clear pass, else write-back
    assign wr_addr = i_cmd.clear ? r_clr : r_set;
    assign wr_row  = i_cmd.clear ? '0 : new_row;

    salc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SETS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clear || i_cmd.commit),
        .i_waddr (wr_addr),
        .i_wdata (wr_row),
        .i_re    (i_cmd.take),
        .i_raddr (set_in),
        .o_rdata (rd_row)
    );

    assign o_status.clear_last = (r_clr == IDX_W'(MAX_SETS - 1));
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_out               = r_out;

    // A read never coincides with a store write
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.take && (i_cmd.clear || i_cmd.commit)))
        else $error("store read and write in the same cycle");

    // A result is loaded only into a free result register
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");

    // After a commit the result is on offer
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("result lost after commit");

    // The miss count moves only on a commit
    a_miss_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.commit && i_rst_n |=> $stable(r_miss))
        else $error("miss count changed without a transaction");

endmodule

`default_nettype wire

// ===== src/set_assoc_lru_cache_tags.sv =====
// Tag and LRU replacement tracking for a set-associative cache.
// i_req (sink) carries one line address per transaction; o_rsp (source)
// returns hit, the hit way's recency position and the running miss count.
// Both channels move a transaction when valid and ready are high at a
// rising edge. i_cfg_we/i_cfg_index/i_cfg_data write set_index_bits
// (index 0) and ways_in_use (index 1); write only while the block is idle.
// The set row is read from the store when a transaction is accepted in
// idle and written back reordered in lookup once the output register is
// free; the result is loaded into that register at the write-back and is
// on offer from then on. A new transaction is accepted only after the last
// is written back, since each one reads its set and then writes it back.
// The result sits in an output register; while the receiver stalls, one
// further transaction is accepted and held in lookup until the register
// frees. After reset a clearing pass empties every one of the MAX_SETS sets
// (8192 by default), one row a cycle; i_req.ready stays low meanwhile.
// Configuration writes are taken during the pass. The miss count resets to
// zero and saturates at its maximum.
`default_nettype none

module set_assoc_lru_cache_tags #(
    parameter int MAX_SETS  = salc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = salc_pkg::MAX_WAYS_DEF,
    parameter int LINE_BITS = salc_pkg::LINE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    salc_stream_if.sink                          i_req,
    salc_stream_if.source                        o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    salc_pkg::t_cmd    cmd;
    salc_pkg::t_status status;
    salc_pkg::t_req    req;

    assign req = i_req.payload;

    // Sequencer
    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Store, search, reorder and counters
    salc_dp #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .LINE_BITS (LINE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_line      (req.line_address),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_out       (o_rsp.payload)
    );

endmodule

`default_nettype wire
